FILE: design/sfir_pkg.sv
package sfir_pkg;

   localparam int SAMPLE_W     = 8;
   localparam int OUT_W        = 16;
   localparam int COEF_W       = 16;
   localparam int NUM_COEF     = 6;
   localparam int CSR_ADDR_W   = 3;
   localparam int TAPS_DEFAULT = 11;
   localparam int ROUND_SHIFT  = 11;
   localparam int OUT_MAX      = 32767;
   localparam int OUT_MIN      = -32768;

   typedef logic [SAMPLE_W-1:0]      sample_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [NUM_COEF-1:0]  coef_bank_type;
   typedef logic [CSR_ADDR_W-1:0]    csr_addr_type;
   typedef logic signed [OUT_W-1:0]  out_type;

   localparam csr_addr_type CSR_COEF_OUTER  = 3'd0;
   localparam csr_addr_type CSR_COEF_SECOND = 3'd1;
   localparam csr_addr_type CSR_COEF_THIRD  = 3'd2;
   localparam csr_addr_type CSR_COEF_FOURTH = 3'd3;
   localparam csr_addr_type CSR_COEF_FIFTH  = 3'd4;
   localparam csr_addr_type CSR_COEF_CENTER = 3'd5;

   function automatic coef_type coef_reset(input csr_addr_type idx);
      coef_type val;
      case (idx)
         CSR_COEF_OUTER:  val = -16'sd98;
         CSR_COEF_SECOND: val = -16'sd430;
         CSR_COEF_THIRD:  val = -16'sd344;
         CSR_COEF_FOURTH: val = 16'sd2741;
         CSR_COEF_FIFTH:  val = 16'sd8608;
         CSR_COEF_CENTER: val = 16'sd11796;
         default:         val = '0;
      endcase
      return val;
   endfunction

   // map a folded tap position to its weight register, clamped at both ends
   function automatic int coef_sel(input int taps, input int fold);
      int sel;
      sel = fold + NUM_COEF - (taps + 1) / 2;
      if (sel < 0) sel = 0;
      if (sel > NUM_COEF - 1) sel = NUM_COEF - 1;
      return sel;
   endfunction

endpackage

FILE: design/sfir_coef_bank.sv
module sfir_coef_bank (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  sfir_pkg::csr_addr_type csr_addr,
   input  sfir_pkg::coef_type    csr_wdata,
   output sfir_pkg::coef_bank_type coefs
);
   import sfir_pkg::*;

   coef_bank_type coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= coef_reset(csr_addr_type'(i));
         end
      end else if (csr_we) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            if (csr_addr == csr_addr_type'(i)) begin
               coef_ff[i] <= csr_wdata;
            end
         end
      end
   end

   assign coefs = coef_ff;

endmodule

FILE: design/sfir_window.sv
module sfir_window #(
   parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  sfir_pkg::sample_type                    in_sample,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [TAPS-1:0][sfir_pkg::SAMPLE_W-1:0] out_window
);
   import sfir_pkg::*;

   logic                           valid_ff;
   logic                           primed_ff;
   logic [TAPS-2:0][SAMPLE_W-1:0]  hist_ff;
   logic [TAPS-2:0][SAMPLE_W-1:0]  hist_in;
   logic [TAPS-1:0][SAMPLE_W-1:0]  win_ff;
   logic [TAPS-1:0][SAMPLE_W-1:0]  win_in;
   logic                           accept;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // prefill the whole line with the first word after reset
   always_comb begin
      win_in[0] = in_sample;
      for (int i = 1; i < TAPS; i++) begin
         win_in[i] = primed_ff ? hist_ff[i-1] : in_sample;
      end
   end

   assign hist_in = win_in[TAPS-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         primed_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            primed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff  <= win_in;
         hist_ff <= hist_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_window = win_ff;

endmodule

FILE: design/sfir_mac.sv
module sfir_mac #(
   parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [TAPS-1:0][sfir_pkg::SAMPLE_W-1:0] in_window,
   input  sfir_pkg::coef_bank_type                 coefs,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output sfir_pkg::out_type                       out_filtered
);
   import sfir_pkg::*;

   localparam int NFOLD  = (TAPS + 1) / 2;
   localparam int PRE_W  = SAMPLE_W + 1;
   localparam int PROD_W = PRE_W + 1 + COEF_W;
   localparam int SUM_W  = PROD_W + $clog2(NFOLD);
   localparam int Q_W    = SUM_W + 1 - ROUND_SHIFT;

   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(OUT_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(OUT_MIN);
   localparam logic signed [SUM_W:0] HALF  = (SUM_W+1)'(1 << (ROUND_SHIFT - 1));

   logic                                    prod_valid_ff;
   logic                                    out_valid_ff;
   logic                                    prod_ready;
   logic signed [NFOLD-1:0][PROD_W-1:0]     prod_in;
   logic signed [NFOLD-1:0][PROD_W-1:0]     prod_ff;
   logic signed [SUM_W-1:0]                 sum;
   logic signed [SUM_W:0]                   biased;
   logic signed [Q_W-1:0]                   quot;
   out_type                                 filtered_in;
   out_type                                 filtered_ff;

   assign prod_ready = !out_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || prod_ready;

   // fold mirrored taps, then one weight per pair or centre tap
   for (genvar f = 0; f < NFOLD; f++) begin : g_fold
      localparam int SEL = coef_sel(TAPS, f);
      logic [PRE_W-1:0]         pre;
      logic signed [PROD_W-1:0] pre_s;
      logic signed [PROD_W-1:0] coef_s;

      if (2 * f == TAPS - 1) begin : g_centre
         assign pre = PRE_W'(in_window[f]);
      end else begin : g_pair
         assign pre = PRE_W'(in_window[f]) + PRE_W'(in_window[TAPS-1-f]);
      end

      assign pre_s      = signed'(PROD_W'(pre));
      assign coef_s     = PROD_W'($signed(coefs[SEL]));
      assign prod_in[f] = pre_s * coef_s;
   end

   always_comb begin
      sum = '0;
      for (int f = 0; f < NFOLD; f++) begin
         sum = sum + SUM_W'($signed(prod_ff[f]));
      end
   end

   // round half up to four fractional bits, then clamp
   assign biased = (SUM_W+1)'(sum) + HALF;
   assign quot   = Q_W'(biased >>> ROUND_SHIFT);

   always_comb begin
      if (quot > Q_MAX) begin
         filtered_in = out_type'(Q_MAX);
      end else if (quot < Q_MIN) begin
         filtered_in = out_type'(Q_MIN);
      end else begin
         filtered_in = out_type'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (prod_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
      if (prod_valid_ff && prod_ready) begin
         filtered_ff <= filtered_in;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_filtered = filtered_ff;

endmodule

FILE: design/symmetric_fir_with_prefill.sv
// Throughput: one word per cycle while rsp_tready is high; the tap window,
// the folded products and the rounded output each sit in a register stage
// that advances on its own.
// Reset (synchronous, active high) restores the six weights, empties the
// pipeline and arms the prefill of the delay line by the next sample.
module symmetric_fir_with_prefill #(
   parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [15:0] filtered
   input  logic                  csr_we,
   input  sfir_pkg::csr_addr_type csr_addr,
   input  sfir_pkg::coef_type    csr_wdata
);
   import sfir_pkg::*;

   coef_bank_type                 coefs;
   logic                          win_valid;
   logic                          win_ready;
   logic [TAPS-1:0][SAMPLE_W-1:0] window;
   out_type                       filtered;

   sfir_coef_bank u_coef_bank (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .coefs     (coefs)
   );

   sfir_window #(.TAPS(TAPS)) u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (sample_type'(req_tdata)),
      .out_valid  (win_valid),
      .out_ready  (win_ready),
      .out_window (window)
   );

   sfir_mac #(.TAPS(TAPS)) u_mac (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (win_valid),
      .in_ready     (win_ready),
      .in_window    (window),
      .coefs        (coefs),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_filtered (filtered)
   );

   assign rsp_tdata = 16'(filtered);

endmodule

FILE: design/sfir_checker.sv
module sfir_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("response word late with the output side ready");

endmodule

bind symmetric_fir_with_prefill sfir_checker u_sfir_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
